@@ src/change_and_periodic_reporter_assert.svh @@
// Assertion macros for the change-and-periodic reporter.
// Used by the top level only; no other dependencies.
`ifndef CHANGE_AND_PERIODIC_REPORTER_ASSERT_SVH
`define CHANGE_AND_PERIODIC_REPORTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/cpr_pkg.sv @@
// Shared types, constants and helper functions of the reporter.
// No dependencies.
package cpr_pkg;

   localparam logic [31:0] SECONDS_AT_RESET = 32'd1451606400;
   localparam logic [7:0]  HB_PERIOD_RESET  = 8'd10;
   localparam logic [7:0]  RF_PERIOD_RESET  = 8'd60;

   localparam logic [1:0] CSR_NODE_ID   = 2'd0;
   localparam logic [1:0] CSR_HB_PERIOD = 2'd1;
   localparam logic [1:0] CSR_RF_PERIOD = 2'd2;

   localparam logic [1:0] KIND_SINGLE  = 2'd0;
   localparam logic [1:0] KIND_DOUBLE  = 2'd1;
   localparam logic [1:0] KIND_VALUE16 = 2'd2;
   localparam logic [1:0] KIND_VALUE32 = 2'd3;

   localparam logic [2:0] MSG_HEARTBEAT = 3'd0;

   localparam logic       MODE_TICK  = 1'b0;
   localparam logic       MODE_WRITE = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [28:0] ident;
      logic [31:0] value;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [28:0] ident;
      logic [2:0]  length;
      logic [31:0] payload;
   } msg_type;

   function automatic logic [31:0] normalize(input logic [1:0] kind, input logic [31:0] v);
      logic [31:0] r;
      case (kind)
         KIND_SINGLE:  r = {31'd0, (v != 32'd0)};
         KIND_DOUBLE:  r = {24'd0, v[7:0]};
         KIND_VALUE16: r = {16'd0, v[15:0]};
         default:      r = v;
      endcase
      return r;
   endfunction

   function automatic msg_type object_msg(input logic [1:0] kind, input logic [28:0] ident,
                                          input logic [31:0] value);
      msg_type m;
      m.kind    = {1'b0, kind} + 3'd1;
      m.ident   = ident;
      case (kind)
         KIND_VALUE16: m.length = 3'd2;
         KIND_VALUE32: m.length = 3'd4;
         default:      m.length = 3'd1;
      endcase
      m.payload = value;
      return m;
   endfunction

endpackage

@@ src/change_and_periodic_reporter.sv @@
// Change-and-periodic reporter: object table, tick handling and refresh scan.
// Top level; depends on cpr_pkg, cpr_table, cpr_mod_unit and the assertion header.
//
// Usage notes
//  - req_ channel: one transfer is a tick (req_tuser = 0) or an object write
//    (req_tuser = 1). req_tready is high only while the block is idle.
//  - rsp_ channel: one transfer per message; rsp_tlast marks the final message
//    caused by one request. A request may cause no message at all.
//  - csr_ port: write-only, taken whenever csr_we is high; write only while idle.
//  - Write: a table read, then the compare, write back and registered message.
//  - Tick: unwritten slots are skipped; each written slot is read from the
//    table, its age runs through the serial remainder unit, and a due slot
//    is resent. Messages drain through a pending register and the output
//    register, so a stalled receiver simply stretches the scan.
//  - Reset: valid bits cleared, seconds counter loaded, periods to defaults;
//    the table contents are left as they are, no clearing pass.
//  - rsp_tready low holds the output register; the scan waits on it.
`include "change_and_periodic_reporter_assert.svh"

module change_and_periodic_reporter import cpr_pkg::*; #(
   parameter int OBJECTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // entry_index[3:0], object_kind[5:4],
                                    // object_ident[34:6], new_value[66:35], zero pad
   input  logic        req_tuser,   // mode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // msg_ident[28:0], msg_length[31:29], msg_payload[63:32]
   output logic [2:0]  rsp_tuser,   // msg_kind
   output logic        rsp_tlast,   // last_of_run
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [28:0] csr_wdata
);

   localparam int IDX_W = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;
   localparam int CNT_W = $clog2(OBJECTS + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_WR_CMP  = 3'd1;
   localparam logic [2:0] ST_SC_SEL  = 3'd2;
   localparam logic [2:0] ST_SC_WAIT = 3'd3;
   localparam logic [2:0] ST_SC_MOD  = 3'd4;
   localparam logic [2:0] ST_SC_EMIT = 3'd5;
   localparam logic [2:0] ST_FLUSH   = 3'd6;

   // request fields
   logic [3:0]  in_index;
   logic [1:0]  in_kind;
   logic [28:0] in_ident;
   logic [31:0] in_value;
   assign in_index = req_tdata[3:0];
   assign in_kind  = req_tdata[5:4];
   assign in_ident = req_tdata[34:6];
   assign in_value = req_tdata[66:35];

   // configuration registers
   logic [28:0] node_id_ff;
   logic [7:0]  hb_period_ff, rf_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff   <= '0;
         hb_period_ff <= HB_PERIOD_RESET;
         rf_period_ff <= RF_PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_NODE_ID:   node_id_ff   <= csr_wdata;
            CSR_HB_PERIOD: hb_period_ff <= csr_wdata[7:0];
            CSR_RF_PERIOD: rf_period_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // control and payload registers
   logic [2:0]       state_ff, state_in;
   logic [31:0]      seconds_ff, seconds_in;
   logic [7:0]       hb_cnt_ff, hb_cnt_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] wr_addr_ff, wr_addr_in;
   logic [1:0]       wr_kind_ff, wr_kind_in;
   logic [28:0]      wr_ident_ff, wr_ident_in;
   logic [31:0]      wr_value_ff, wr_value_in;
   msg_type          pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   msg_type          out_ff, out_in;
   logic             out_last_ff, out_last_in;
   logic             out_valid_ff, out_valid_in;

   // table and remainder unit
   logic               tb_rd_en, tb_wr_en;
   logic [IDX_W-1:0]   tb_rd_addr;
   entry_type          tb_rd_data, tb_wr_data;
   logic [OBJECTS-1:0] tb_valid;
   logic               mod_start, mod_busy, mod_zero;
   logic [7:0]         rf_eff, hb_eff;

   cpr_table #(.OBJECTS(OBJECTS), .IDX_W(IDX_W)) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tb_rd_en),
      .rd_addr (tb_rd_addr),
      .rd_data (tb_rd_data),
      .wr_en   (tb_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (tb_wr_data),
      .valid   (tb_valid)
   );

   cpr_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (seconds_ff - tb_rd_data.stamp),
      .divisor  (rf_eff),
      .busy     (mod_busy),
      .rem_zero (mod_zero)
   );

   assign rf_eff = (rf_period_ff == 8'd0) ? 8'd1 : rf_period_ff;
   assign hb_eff = (hb_period_ff == 8'd0) ? 8'd1 : hb_period_ff;

   assign tb_wr_data.kind  = wr_kind_ff;
   assign tb_wr_data.ident = wr_ident_ff;
   assign tb_wr_data.value = wr_value_ff;
   assign tb_wr_data.stamp = seconds_ff - 32'd1;

   logic             req_xfer, out_free, wr_changed;
   logic [6:0]       idx_wide;
   logic [6:0]       scan_wide;
   logic [IDX_W-1:0] scan_addr;
   logic [7:0]       hb_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign idx_wide   = {3'd0, in_index};
   assign scan_wide  = 7'(scan_ff);
   assign scan_addr  = scan_wide[IDX_W-1:0];
   assign hb_next    = hb_cnt_ff + 8'd1;
   assign wr_changed = !(tb_valid[wr_addr_ff] && tb_rd_data.kind == wr_kind_ff &&
                         tb_rd_data.ident == wr_ident_ff && tb_rd_data.value == wr_value_ff);

   always_comb begin
      state_in      = state_ff;
      seconds_in    = seconds_ff;
      hb_cnt_in     = hb_cnt_ff;
      scan_in       = scan_ff;
      wr_addr_in    = wr_addr_ff;
      wr_kind_in    = wr_kind_ff;
      wr_ident_in   = wr_ident_ff;
      wr_value_in   = wr_value_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      tb_rd_en      = 1'b0;
      tb_rd_addr    = idx_wide[IDX_W-1:0];
      tb_wr_en      = 1'b0;
      mod_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               wr_addr_in  = idx_wide[IDX_W-1:0];
               wr_kind_in  = in_kind;
               wr_ident_in = in_ident;
               wr_value_in = normalize(in_kind, in_value);
               if (req_tuser == MODE_WRITE) begin
                  if (idx_wide < 7'(OBJECTS)) begin
                     tb_rd_en = 1'b1;
                     state_in = ST_WR_CMP;
                  end
               end else begin
                  seconds_in = seconds_ff + 32'd1;
                  scan_in    = '0;
                  state_in   = ST_SC_SEL;
                  if (hb_next >= hb_eff) begin
                     hb_cnt_in     = '0;
                     pend_in       = '{kind: MSG_HEARTBEAT, ident: node_id_ff,
                                       length: 3'd1, payload: 32'd1};
                     pend_valid_in = 1'b1;
                  end else begin
                     hb_cnt_in = hb_next;
                  end
               end
            end
         end
         ST_WR_CMP: begin
            if (!wr_changed) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               tb_wr_en     = 1'b1;
               out_in       = object_msg(wr_kind_ff, wr_ident_ff, wr_value_ff);
               out_last_in  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SC_SEL: begin
            tb_rd_addr = scan_addr;
            if (scan_ff == CNT_W'(OBJECTS)) begin
               state_in = ST_FLUSH;
            end else if (tb_valid[scan_addr]) begin
               tb_rd_en = 1'b1;
               state_in = ST_SC_WAIT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_SC_WAIT: begin
            mod_start = 1'b1;
            state_in  = ST_SC_MOD;
         end
         ST_SC_MOD: begin
            if (!mod_busy) begin
               if (mod_zero) begin
                  state_in = ST_SC_EMIT;
               end else begin
                  scan_in  = scan_ff + 1'b1;
                  state_in = ST_SC_SEL;
               end
            end
         end
         ST_SC_EMIT: begin
            // a due entry replaces the pending message, which moves out not last
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_in       = pend_ff;
                  out_last_in  = 1'b0;
                  out_valid_in = 1'b1;
               end
               pend_in       = object_msg(tb_rd_data.kind, tb_rd_data.ident, tb_rd_data.value);
               pend_valid_in = 1'b1;
               scan_in       = scan_ff + 1'b1;
               state_in      = ST_SC_SEL;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seconds_ff    <= SECONDS_AT_RESET;
         hb_cnt_ff     <= '0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seconds_ff    <= seconds_in;
         hb_cnt_ff     <= hb_cnt_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      wr_addr_ff  <= wr_addr_in;
      wr_kind_ff  <= wr_kind_in;
      wr_ident_ff <= wr_ident_in;
      wr_value_ff <= wr_value_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.payload, out_ff.length, out_ff.ident};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

   // pending message always flushed before the block takes the next request
   `CPR_ASSERT_IMPL(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff, "pending message left at idle")
   // remainder unit only runs in the scan's remainder state
   `CPR_ASSERT_IMPL(a_mod_in_scan, clock, reset, mod_busy, state_ff == ST_SC_MOD, "remainder unit busy outside scan")
   // a tick transfer advances the seconds counter by one
   `CPR_ASSERT_NEXT(a_tick_sec, clock, reset, req_xfer && req_tuser == MODE_TICK, seconds_ff == $past(seconds_ff) + 32'd1, "seconds not advanced on tick")

endmodule

@@ src/cpr_table.sv @@
// Object table: synchronous memory with a registered read port plus valid bits.
// Depends on cpr_pkg.
module cpr_table import cpr_pkg::*; #(
   parameter int OBJECTS = 16,
   parameter int IDX_W   = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output entry_type          rd_data,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  entry_type          wr_data,
   output logic [OBJECTS-1:0] valid
);

   entry_type          mem [OBJECTS];
   entry_type          rd_data_ff;
   logic [OBJECTS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule

@@ src/cpr_mod_unit.sv @@
// Remainder of a 32-bit age by an 8-bit period, four quotient bits a cycle.
// Depends on cpr_pkg only for house consistency of imports.
module cpr_mod_unit import cpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [7:0]  divisor,
   output logic        busy,
   output logic        rem_zero
);

   localparam int BITS_PER_STEP = 4;
   localparam int STEPS         = 32 / BITS_PER_STEP;

   logic        busy_ff, busy_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  div_ff, div_in;

   always_comb begin
      logic [8:0] r;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      r       = {1'b0, rem_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         for (int k = 0; k < BITS_PER_STEP; k++) begin
            r = {r[7:0], dvd_ff[31-k]};
            if (r >= {1'b0, div_ff}) begin
               r = r - {1'b0, div_ff};
            end
         end
         rem_in = r[7:0];
         dvd_in = {dvd_ff[31-BITS_PER_STEP:0], {BITS_PER_STEP{1'b0}}};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign rem_zero = (rem_ff == 8'd0);

endmodule

@@ verif/change_and_periodic_reporter_test.sv @@
// Self-checking testbench for the change-and-periodic reporter.
// Depends on cpr_pkg and the change_and_periodic_reporter top level.
module change_and_periodic_reporter_test;
   import cpr_pkg::*;

   localparam int SLOTS      = 16;
   localparam int SCAN_CYCLES = 220;      // a full tick scan with every slot written
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 400;

   // one message as seen on the response channel
   typedef struct packed {
      logic [2:0]  kind;
      logic [28:0] ident;
      logic [2:0]  len;
      logic [31:0] payload;
      logic        last;
   } report_msg_type;

   // Mirror of the object table; predicts the messages of every transfer.
   class reporter_scoreboard;
      logic [28:0] node;
      logic [7:0]  hb_period, rf_period, hb_count;
      logic [31:0] seconds;
      logic        valid [SLOTS];
      logic [1:0]  kind  [SLOTS];
      logic [28:0] ident [SLOTS];
      logic [31:0] value [SLOTS], stamp [SLOTS];
      report_msg_type pending_msgs[$];
      int          errors, msgs_seen, writes, ticks;

      function new();
         node = '0; hb_period = HB_PERIOD_RESET; rf_period = RF_PERIOD_RESET;
         seconds = SECONDS_AT_RESET; hb_count = '0;
         foreach (valid[i]) valid[i] = 1'b0;
         errors = 0; msgs_seen = 0; writes = 0; ticks = 0;
      endfunction

      function void set_register(logic [1:0] addr, logic [28:0] data);
         case (addr)
            CSR_NODE_ID:   node = data;
            CSR_HB_PERIOD: hb_period = data[7:0];
            CSR_RF_PERIOD: rf_period = data[7:0];
            default: ;
         endcase
      endfunction

      function report_msg_type slot_msg(logic [1:0] k, logic [28:0] id, logic [31:0] v);
         report_msg_type m;
         m.kind = {1'b0, k} + 3'd1;
         m.ident = id;
         m.len = (k == KIND_VALUE32) ? 3'd4 : (k == KIND_VALUE16) ? 3'd2 : 3'd1;
         m.payload = v;
         m.last = 1'b0;
         return m;
      endfunction

      function void note_request(logic mode, logic [3:0] idx, logic [1:0] k,
                                 logic [28:0] id, logic [31:0] raw);
         logic [31:0] v, age;
         int          hp, rp, n;
         report_msg_type m;
         n = 0;
         if (mode == MODE_WRITE) begin
            writes++;
            case (k)
               KIND_SINGLE:  v = {31'd0, raw != 32'd0};
               KIND_DOUBLE:  v = {24'd0, raw[7:0]};
               KIND_VALUE16: v = {16'd0, raw[15:0]};
               default:      v = raw;
            endcase
            // unchanged object: nothing stored, nothing sent
            if (valid[idx] && kind[idx] == k && ident[idx] == id && value[idx] == v)
               return;
            valid[idx] = 1'b1; kind[idx] = k; ident[idx] = id; value[idx] = v;
            stamp[idx] = seconds - 32'd1;
            m = slot_msg(k, id, v);
            m.last = 1'b1;
            pending_msgs.push_back(m);
            return;
         end
         ticks++;
         hp = (hb_period == 0) ? 1 : hb_period;
         rp = (rf_period == 0) ? 1 : rf_period;
         seconds = seconds + 32'd1;
         hb_count = hb_count + 8'd1;
         if (int'(hb_count) > hp - 1) begin
            hb_count = '0;
            m.kind = MSG_HEARTBEAT; m.ident = node; m.len = 3'd1;
            m.payload = 32'd1; m.last = 1'b0;
            pending_msgs.push_back(m);
            n++;
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (!valid[i]) continue;
            age = seconds - stamp[i];
            if (age % rp == 0) begin
               pending_msgs.push_back(slot_msg(kind[i], ident[i], value[i]));
               n++;
            end
         end
         if (n > 0) pending_msgs[pending_msgs.size() - 1].last = 1'b1;
      endfunction

      task report(string what);
         errors++;
         $display("mismatch @%0t: %s", $time, what);
      endtask

      task check_message(report_msg_type got);
         report_msg_type want;
         msgs_seen++;
         if (pending_msgs.size() == 0) begin
            report($sformatf("unexpected message kind %0d ident %h", got.kind, got.ident));
            return;
         end
         want = pending_msgs.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
         if (got.ident !== want.ident)
            report($sformatf("ident %h, wanted %h", got.ident, want.ident));
         if (got.len !== want.len)
            report($sformatf("length %0d, wanted %0d", got.len, want.len));
         if (got.payload !== want.payload)
            report($sformatf("payload %h, wanted %h", got.payload, want.payload));
         if (got.last !== want.last)
            report($sformatf("last %b, wanted %b", got.last, want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // entry_index, object_kind, object_ident, new_value, pad
   logic        req_tuser = MODE_TICK;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;   // msg_ident, msg_length, msg_payload
   logic [2:0]  rsp_tuser;   // msg_kind
   logic        rsp_tlast;   // last_of_run
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = CSR_NODE_ID;
   logic [28:0] csr_wdata = '0;

   // calm: no idling on either side; hold_go asks the receiver for one long hold-off
   logic        calm = 1'b0;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;
   int          cycles = 0;

   reporter_scoreboard sb = new();

   change_and_periodic_reporter u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Transfers are sampled at the edge, before any of this edge's updates land.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tuser, req_tdata[3:0], req_tdata[5:4], req_tdata[34:6],
                         req_tdata[66:35]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_message({rsp_tuser, rsp_tdata[28:0], rsp_tdata[31:29],
                           rsp_tdata[63:32], rsp_tlast});
   end

   // Receiver: random stalls, one long hold-off on request, none while calm.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 12);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d messages outstanding",
                  cycles, sb.pending_msgs.size());
         $display("[change_and_periodic_reporter] ERROR");
         $finish;
      end
   end

   // One request transfer; returns at the edge where it was taken.
   task send(logic mode, logic [3:0] idx, logic [1:0] k, logic [28:0] id, logic [31:0] v);
      int gap;
      gap = (!calm && $urandom_range(99) < 12) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {5'd0, v, id, k, idx};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task tick();
      send(MODE_TICK, 4'($urandom), 2'($urandom), 29'($urandom), $urandom);
   endtask

   // Sender pause: everything predicted has arrived, then the scan may still run on.
   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_msgs.size() != 0) @(posedge clock);
      repeat (SCAN_CYCLES) @(posedge clock);
   endtask

   task write_csr(logic [1:0] addr, logic [28:0] data);
      csr_we <= 1'b1; csr_addr <= addr; csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_register(addr, data);
      @(posedge clock);
   endtask

   task set_periods(logic [28:0] node, logic [7:0] hb, logic [7:0] rf);
      drain();
      write_csr(CSR_NODE_ID, node);
      write_csr(CSR_HB_PERIOD, {21'd0, hb});
      write_csr(CSR_RF_PERIOD, {21'd0, rf});
   endtask

   // Random traffic: mostly writes that land on a small pool of identities so
   // that unchanged rewrites and refresh ages both turn up; ticks in between.
   task random_run(int count, int tick_pct);
      logic [31:0] v;
      logic [28:0] id;
      logic [3:0]  idx;
      logic [1:0]  k;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < tick_pct) begin
            tick();
         end else begin
            idx = 4'($urandom);
            k   = 2'($urandom);
            id  = ($urandom_range(1) == 0) ? 29'($urandom_range(3)) : 29'($urandom);
            case ($urandom_range(4))
               0: v = 32'd0;
               1: v = 32'hFFFF_FFFF;
               2: v = 32'($urandom_range(2));
               default: v = $urandom;
            endcase
            send(MODE_WRITE, idx, k, id, v);
            // repeat the same write now and then: no message is due
            if ($urandom_range(3) == 0) send(MODE_WRITE, idx, k, id, v);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every kind, field extremes, first write, unchanged and
      // re-typed rewrites, then ticks with the shortest periods.
      set_periods(29'h1FFF_FFFF, 8'd1, 8'd1);
      send(MODE_WRITE, 4'd0, KIND_SINGLE, 29'd0, 32'd0);
      send(MODE_WRITE, 4'd0, KIND_SINGLE, 29'd0, 32'd5);
      send(MODE_WRITE, 4'd0, KIND_SINGLE, 29'd0, 32'h8000_0000);
      send(MODE_WRITE, 4'd1, KIND_DOUBLE, 29'h155, 32'hFFFF_FF80);
      send(MODE_WRITE, 4'd1, KIND_DOUBLE, 29'h155, 32'h0000_0080);
      send(MODE_WRITE, 4'd2, KIND_VALUE16, 29'h0AAA_AAAA, 32'h8000_1234);
      send(MODE_WRITE, 4'd3, KIND_VALUE32, 29'h1555_5555, 32'h8000_0000);
      send(MODE_WRITE, 4'd3, KIND_VALUE32, 29'h1555_5555, 32'h7FFF_FFFF);
      send(MODE_WRITE, 4'd15, KIND_VALUE32, 29'h1FFF_FFFF, 32'hFFFF_FFFF);
      send(MODE_WRITE, 4'd15, KIND_VALUE32, 29'h1FFF_FFFF, 32'hFFFF_FFFF);
      send(MODE_WRITE, 4'd15, KIND_VALUE32, 29'd7, 32'hFFFF_FFFF);
      send(MODE_WRITE, 4'd15, KIND_SINGLE, 29'd7, 32'hFFFF_FFFF);
      repeat (3) tick();

      // Longest periods; build the heartbeat count, then lower the period
      // below it so the next tick must fire and clear it.
      set_periods(29'd0, 8'd255, 8'd255);
      repeat (6) tick();
      set_periods(29'h0123_4567, 8'd3, 8'd255);
      repeat (4) tick();

      // Zero periods behave as one: heartbeat and full resend on every tick.
      set_periods(29'h1000_0000, 8'd0, 8'd0);
      repeat (3) tick();

      // Random part, no idling for the first stretch.
      set_periods(29'($urandom), 8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)));
      calm <= 1'b1;
      random_run(50, 35);
      calm <= 1'b0;
      random_run(50, 35);

      // Long receiver hold-off while requests keep coming.
      set_periods(29'($urandom), 8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)));
      hold_go <= 1'b1;
      random_run(80, 50);

      set_periods(29'($urandom), 8'($urandom_range(2, 20)), 8'($urandom_range(2, 12)));
      random_run(100, 40);

      set_periods(29'($urandom), 8'd255, 8'd1);
      random_run(60, 30);

      drain();
      $display("covered %0d writes and %0d ticks, %0d messages checked",
               sb.writes, sb.ticks, sb.msgs_seen);
      $display("periods from zero to 255, one long receiver hold-off");
      if (sb.errors == 0) begin
         $display("[change_and_periodic_reporter] OK");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("[change_and_periodic_reporter] ERROR");
      end
      $finish;
   end

endmodule
